// ----- design/drs_pkg.sv -----
// Package for the disk request scheduler: policy codes, widths, defaults.
// No dependencies.
package drs_pkg;
    localparam int DefQueueDepth = 16;
    localparam int IdW   = 16;
    localparam int ArrW  = 32;
    localparam int CylW  = 16;
    localparam int AdrW  = 32;
    localparam int ProW  = 16;

    localparam logic [1:0] POL_FCFS = 2'd0;
    localparam logic [1:0] POL_SSTF = 2'd1;
    localparam logic [1:0] POL_LOOK = 2'd2;

    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_DONE   = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch input beat
        logic arrive;    // apply arrival
        logic scan_init; // clear scan state
        logic scan_step; // compare one slot
        logic take;      // load chosen slot into active
        logic idle_out;  // clear active (empty queue)
        logic shift;     // move one slot down
        logic finish;    // pulse result strobe
    } drs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_done;
        logic queue_empty;
        logic scan_last;
        logic shift_last;
    } drs_stat_t;
endpackage

// ----- design/disk_request_scheduler.sv -----
// Top level of the disk request scheduler.
// Depends on drs_pkg, drs_ctrl and drs_datapath.
//
// One event at a time: pulse start while busy is low. An arrival, or a
// completion with an empty queue, passes through the decode and done
// states before its registered done strobe. A completion with queued
// requests first sweeps the single-read-port queue memory to pick a
// request, then reads the winner and moves later slots down. Results
// appear on the serving_* ports and the flags for one cycle with done
// high; the receiver cannot stall, so it must take them then.
// busy is already low in the done cycle, so the next start can be taken at
// the edge that ends it. The output ports keep the last state between
// strobes. Policy is written through cfg_valid/cfg_ready; cfg_ready is high
// only while idle; codes outside the list behave as FCFS.
module disk_request_scheduler
    import drs_pkg::*;
#(
    parameter int QUEUE_DEPTH = DefQueueDepth
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_data,
    input  logic            operation,
    input  logic [IdW-1:0]  req_id,
    input  logic [ArrW-1:0] req_arrival,
    input  logic [CylW-1:0] req_cylinder,
    input  logic [AdrW-1:0] req_address,
    input  logic [ProW-1:0] req_process,
    input  logic [CylW-1:0] head_cylinder,
    input  logic            scan_up,
    output logic            done,
    output logic [IdW-1:0]  serving_id,
    output logic [ArrW-1:0] serving_arrival,
    output logic [CylW-1:0] serving_cylinder,
    output logic [AdrW-1:0] serving_address,
    output logic [ProW-1:0] serving_process,
    output logic            disk_busy,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] pending_count,
    output logic            dropped
);
    drs_cmd_t   cmd;
    drs_stat_t  stat;
    logic [1:0] policy_reg;

    // policy must not move under a running scan
    assign cfg_ready = !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            policy_reg <= POL_FCFS;
        else if (cfg_valid && cfg_ready)
            policy_reg <= cfg_data;
    end

    drs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    drs_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .policy           (policy_reg),
        .operation        (operation),
        .req_id           (req_id),
        .req_arrival      (req_arrival),
        .req_cylinder     (req_cylinder),
        .req_address      (req_address),
        .req_process      (req_process),
        .head_cylinder    (head_cylinder),
        .scan_up          (scan_up),
        .serving_id       (serving_id),
        .serving_arrival  (serving_arrival),
        .serving_cylinder (serving_cylinder),
        .serving_address  (serving_address),
        .serving_process  (serving_process),
        .disk_busy        (disk_busy),
        .pending_count    (pending_count),
        .dropped          (dropped),
        .done             (done)
    );
endmodule

// ----- design/drs_ctrl.sv -----
// Controller state machine for the disk request scheduler.
// Depends on drs_pkg.
module drs_ctrl
    import drs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  drs_stat_t stat,
    output drs_cmd_t  cmd
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DEC   = 6'b000010,
        S_SCAN  = 6'b000100,
        S_TAKE  = 6'b001000,
        S_SHIFT = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (!stat.is_done)
                begin
                    cmd.arrive = 1'b1;
                    state_next = S_DONE;
                end
                else if (stat.queue_empty)
                begin
                    cmd.idle_out = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                    state_next = S_TAKE;
            end
            S_TAKE:
            begin
                cmd.take = 1'b1;
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                if (stat.shift_last)
                    state_next = S_DONE;
                else
                    cmd.shift = 1'b1;
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);
endmodule

// ----- design/drs_datapath.sv -----
// Datapath for the disk request scheduler: queue memory, scan, active request.
// Depends on drs_pkg.
module drs_datapath
    import drs_pkg::*;
#(
    parameter int QUEUE_DEPTH = DefQueueDepth
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  drs_cmd_t        cmd,
    output drs_stat_t       stat,
    input  logic [1:0]      policy,
    input  logic            operation,
    input  logic [IdW-1:0]  req_id,
    input  logic [ArrW-1:0] req_arrival,
    input  logic [CylW-1:0] req_cylinder,
    input  logic [AdrW-1:0] req_address,
    input  logic [ProW-1:0] req_process,
    input  logic [CylW-1:0] head_cylinder,
    input  logic            scan_up,
    output logic [IdW-1:0]  serving_id,
    output logic [ArrW-1:0] serving_arrival,
    output logic [CylW-1:0] serving_cylinder,
    output logic [AdrW-1:0] serving_address,
    output logic [ProW-1:0] serving_process,
    output logic            disk_busy,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] pending_count,
    output logic            dropped,
    output logic            done
);
    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH+1);
    localparam int EW = IdW + ArrW + CylW + AdrW + ProW;

    // LOOK ranking, lower wins
    localparam logic [1:0] CLS_HEAD  = 2'd0;
    localparam logic [1:0] CLS_AHEAD = 2'd1;
    localparam logic [1:0] CLS_OTHER = 2'd2;

    typedef struct packed {
        logic [IdW-1:0]  id;
        logic [ArrW-1:0] arr;
        logic [CylW-1:0] cyl;
        logic [AdrW-1:0] adr;
        logic [ProW-1:0] pro;
    } entry_t;

    logic [EW-1:0] mem [QUEUE_DEPTH];

    entry_t         in_reg, act_reg, rd_reg;
    logic           op_reg, up_reg, drop_reg, done_reg;
    logic [CylW-1:0] head_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  idx_reg;      // scan read pointer / shift pointer
    logic           rdv_reg;      // rd_reg holds slot rdi_reg
    logic [IW-1:0]  rdi_reg;
    logic [IW-1:0]  best_reg;
    logic [IW-1:0]  wa_reg;       // shift write target
    logic [ArrW-1:0] barr_reg;
    logic [CylW-1:0] bd_reg;
    logic [1:0]     bcls_reg;
    logic           found_reg;
    logic           shift_wr_reg;
    logic           take_d_reg;   // chosen entry sits in rd_reg

    logic [IW-1:0]  raddr;
    logic [CW-1:0]  idx_p1;
    logic [CylW-1:0] gap;
    logic [1:0]     cls;
    logic           better;
    entry_t         cand;

    // read address: take reads the winner, shift reads idx+1, scan reads idx
    assign idx_p1 = idx_reg + CW'(1);
    always_comb
    begin
        if (cmd.take)
            raddr = best_reg;
        else if (cmd.shift)
            raddr = idx_p1[IW-1:0];
        else
            raddr = idx_reg[IW-1:0];
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= mem[raddr];
        if (cmd.arrive && act_reg.id != '0 && count_reg < CW'(QUEUE_DEPTH))
            mem[count_reg[IW-1:0]] <= in_reg;
        else if (shift_wr_reg)
            mem[wa_reg] <= rd_reg;
    end

    // candidate evaluation
    assign cand = rd_reg;
    assign gap  = (cand.cyl > head_reg) ? cand.cyl - head_reg : head_reg - cand.cyl;
    always_comb
    begin
        if (cand.cyl == head_reg)
            cls = CLS_HEAD;
        else if (up_reg ? (cand.cyl > head_reg) : (cand.cyl < head_reg))
            cls = CLS_AHEAD;
        else
            cls = CLS_OTHER;
        case (policy)
            POL_SSTF: better = (gap < bd_reg) ||
                               (gap == bd_reg && cand.arr < barr_reg);
            POL_LOOK:
            begin
                if (cls != bcls_reg)
                    better = cls < bcls_reg;
                else if (cls == CLS_HEAD)
                    better = cand.arr < barr_reg;
                else
                    better = gap < bd_reg;
            end
            default:  better = cand.arr < barr_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg      <= '0;
            count_reg    <= '0;
            drop_reg     <= 1'b0;
            done_reg     <= 1'b0;
            rdv_reg      <= 1'b0;
            found_reg    <= 1'b0;
            shift_wr_reg <= 1'b0;
            take_d_reg   <= 1'b0;
            idx_reg      <= '0;
            rdi_reg      <= '0;
            best_reg     <= '0;
            wa_reg       <= '0;
            barr_reg     <= '0;
            bd_reg       <= '0;
            bcls_reg     <= CLS_HEAD;
        end
        else
        begin
            done_reg     <= cmd.finish;
            shift_wr_reg <= cmd.shift;
            take_d_reg   <= cmd.take;
            if (cmd.capture)
                drop_reg <= 1'b0;
            if (cmd.arrive)
            begin
                if (act_reg.id == '0)
                    act_reg <= in_reg;
                else if (count_reg < CW'(QUEUE_DEPTH))
                    count_reg <= count_reg + CW'(1);
                else
                    drop_reg <= 1'b1;
            end
            if (cmd.idle_out)
                act_reg <= '0;
            if (cmd.scan_init)
            begin
                idx_reg   <= '0;
                rdv_reg   <= 1'b0;
                found_reg <= 1'b0;
            end
            if (cmd.scan_step)
            begin
                // issue reads while idx < count; evaluate previous read
                if (idx_reg < count_reg)
                    idx_reg <= idx_p1;
                rdv_reg <= (idx_reg < count_reg);
                rdi_reg <= idx_reg[IW-1:0];
                if (rdv_reg && (!found_reg || better))
                begin
                    found_reg <= 1'b1;
                    best_reg  <= rdi_reg;
                    barr_reg  <= cand.arr;
                    bd_reg    <= gap;
                    bcls_reg  <= cls;
                end
            end
            if (cmd.take)
            begin
                idx_reg   <= CW'(best_reg);
                rdv_reg   <= 1'b0;
                count_reg <= count_reg - CW'(1);
            end
            // one slot per cycle: read idx+1 now, write it to idx next cycle
            if (cmd.shift)
            begin
                wa_reg  <= idx_reg[IW-1:0];
                idx_reg <= idx_p1;
            end
            if (take_d_reg)
                act_reg <= rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg   <= '{req_id, req_arrival, req_cylinder, req_address, req_process};
            op_reg   <= operation;
            head_reg <= head_cylinder;
            up_reg   <= scan_up;
        end
    end

    // scan ends once the last read has been evaluated
    assign stat.is_done     = (op_reg == OP_DONE);
    assign stat.queue_empty = (count_reg == '0);
    assign stat.scan_last   = rdv_reg && !(idx_reg < count_reg);
    // count already dropped at take: slots idx+1 .. count move down by one
    assign stat.shift_last  = !(idx_reg < count_reg);

    assign serving_id       = act_reg.id;
    assign serving_arrival  = act_reg.arr;
    assign serving_cylinder = act_reg.cyl;
    assign serving_address  = act_reg.adr;
    assign serving_process  = act_reg.pro;
    assign disk_busy        = (act_reg.id != '0);
    assign pending_count    = count_reg;
    assign dropped          = drop_reg;
    assign done             = done_reg;
endmodule

// ----- design/drs_checker.sv -----
// Port-level checker for the disk request scheduler, bound to the top level.
// Depends on drs_pkg.
module drs_checker
    import drs_pkg::*;
#(
    parameter int QUEUE_DEPTH = DefQueueDepth
)
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [IdW-1:0] serving_id,
    input logic       disk_busy,
    input logic [$clog2(QUEUE_DEPTH+1)-1:0] pending_count,
    input logic       dropped
);
    localparam int CW = $clog2(QUEUE_DEPTH+1);

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("start not taken");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while still busy");
    a_busy_flag: assert property (@(posedge clk) disable iff (!rst_n)
        disk_busy == (serving_id != '0)) else $error("disk_busy mismatch");
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        done && dropped |-> pending_count == CW'(QUEUE_DEPTH)) else $error("drop not full");
endmodule

bind disk_request_scheduler drs_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .serving_id    (serving_id),
    .disk_busy     (disk_busy),
    .pending_count (pending_count),
    .dropped       (dropped)
);
